[hw/rtl/dqle_pkg.sv]
package dqle_pkg;

    // name limits
    localparam int LABEL_MAX   = 32;
    localparam int ADDR_CHARS  = 15;
    localparam int GROUPS      = 4;
    localparam int GROUP_CHARS = 3;
    localparam int OCT_DEPTH   = GROUPS * GROUP_CHARS;
    localparam int SFX_LEN     = 13;

    // derived widths
    localparam int LBL_IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam int LBL_CNT_W = $clog2(LABEL_MAX + 1);
    localparam int PTR_W     = (LBL_IDX_W > 4) ? LBL_IDX_W : 4;

    // characters
    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] ZERO_CHAR = 8'h30;
    localparam logic [7:0] NINE_CHAR = 8'h39;

    // output byte source select
    localparam logic [2:0] SEL_LLEN  = 3'd0;
    localparam logic [2:0] SEL_LBYTE = 3'd1;
    localparam logic [2:0] SEL_GLEN  = 3'd2;
    localparam logic [2:0] SEL_GBYTE = 3'd3;
    localparam logic [2:0] SEL_SFX   = 3'd4;
    localparam logic [2:0] SEL_FINAL = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       absorb;
        logic       set_err;
        logic       clr_count;
        logic       clear_name;
        logic       ptr_clr;
        logic       ptr_inc;
        logic       grp_load;
        logic       grp_dec;
        logic       emit;
        logic [2:0] sel;
    } dqle_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic mode;
        logic is_dot;
        logic eos;
        logic count_zero;
        logic err;
        logic label_last;
        logic group_last;
        logic grp_zero;
        logic tail_err;
        logic sfx_last;
        logic out_free;
    } dqle_stat_t;

    // length-prefixed in-addr and arpa labels
    function automatic logic [7:0] sfx_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'd7;
            4'd1:    b = 8'h69;
            4'd2:    b = 8'h6E;
            4'd3:    b = 8'h2D;
            4'd4:    b = 8'h61;
            4'd5:    b = 8'h64;
            4'd6:    b = 8'h64;
            4'd7:    b = 8'h72;
            4'd8:    b = 8'd4;
            4'd9:    b = 8'h61;
            4'd10:   b = 8'h72;
            4'd11:   b = 8'h70;
            4'd12:   b = 8'h61;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/dqle_datapath.sv]
module dqle_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           name_char,
    input  logic                 end_of_name,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic                 out_ready,
    input  dqle_pkg::dqle_cmd_t  cmd,
    output dqle_pkg::dqle_stat_t stat,
    output logic                 out_valid,
    output logic [7:0]           wire_byte,
    output logic                 final_byte,
    output logic                 bad_name
);

    localparam int IW = dqle_pkg::LBL_IDX_W;
    localparam int CW = dqle_pkg::LBL_CNT_W;
    localparam int PW = dqle_pkg::PTR_W;

    logic                 mode_reg;
    logic [7:0]           char_reg;
    logic                 eos_reg;
    logic [7:0]           label_mem [dqle_pkg::LABEL_MAX];
    logic [7:0]           oct_mem [dqle_pkg::OCT_DEPTH];
    logic [CW-1:0]        count_reg;
    logic [1:0]           len_reg [dqle_pkg::GROUPS];
    logic [1:0]           idx_reg;
    logic                 err_reg;
    logic [PW-1:0]        ptr_reg;
    logic [1:0]           grp_reg;
    logic                 out_valid_reg;
    logic [7:0]           byte_reg;
    logic                 final_reg;
    logic                 bad_reg;

    logic                 is_dot;
    logic                 is_digit;
    logic [1:0]           cur_len;
    logic                 lbl_full;
    logic                 lbl_wr;
    logic                 oct_wr;
    logic [3:0]           oct_wr_addr;
    logic [3:0]           oct_rd_addr;
    logic [4:0]           total;
    logic                 out_free;

    // decode of the held character
    assign is_dot   = (char_reg == dqle_pkg::DOT_CHAR);
    assign is_digit = (char_reg >= dqle_pkg::ZERO_CHAR) && (char_reg <= dqle_pkg::NINE_CHAR);
    assign cur_len  = len_reg[idx_reg];
    assign lbl_full = (count_reg >= CW'(dqle_pkg::LABEL_MAX));

    // store writes on absorb
    assign lbl_wr = cmd.absorb && !mode_reg && !is_dot && !lbl_full;
    assign oct_wr = cmd.absorb && mode_reg && is_digit && (cur_len != 2'd3);
    assign oct_wr_addr = {2'b00, idx_reg} * 4'd3 + {2'b00, cur_len};
    assign oct_rd_addr = {2'b00, grp_reg} * 4'd3 + {2'b00, ptr_reg[1:0]};

    // address length check: group count minus one plus all digits
    always_comb
    begin
        total = {3'b000, idx_reg};
        for (int g = 0; g < dqle_pkg::GROUPS; g++)
        begin
            if (2'(g) <= idx_reg)
                total = total + {3'b000, len_reg[g]};
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // status to controller
    always_comb
    begin
        stat            = '0;
        stat.mode       = mode_reg;
        stat.is_dot     = is_dot;
        stat.eos        = eos_reg;
        stat.count_zero = (count_reg == '0);
        stat.err        = err_reg;
        stat.label_last = ((CW+1)'(ptr_reg) + (CW+1)'(1)) == (CW+1)'(count_reg);
        stat.group_last = (ptr_reg[1:0] + 2'd1) == len_reg[grp_reg];
        stat.grp_zero   = (grp_reg == 2'd0);
        stat.tail_err   = is_dot || (cur_len == 2'd0) ||
                          (total > 5'(dqle_pkg::ADDR_CHARS));
        stat.sfx_last   = (ptr_reg == PW'(dqle_pkg::SFX_LEN - 1));
        stat.out_free   = out_free;
    end

    // input hold register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= name_char;
            eos_reg  <= end_of_name;
        end
    end

    // label and octet stores
    always_ff @(posedge clk)
    begin
        if (lbl_wr)
            label_mem[count_reg[IW-1:0]] <= char_reg;
        if (oct_wr)
            oct_mem[oct_wr_addr] <= char_reg;
    end

    // name state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
            idx_reg   <= 2'd0;
            err_reg   <= 1'b0;
            for (int g = 0; g < dqle_pkg::GROUPS; g++)
                len_reg[g] <= 2'd0;
        end
        else if (cfg_we || cmd.clear_name)
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            count_reg <= '0;
            idx_reg   <= 2'd0;
            err_reg   <= 1'b0;
            for (int g = 0; g < dqle_pkg::GROUPS; g++)
                len_reg[g] <= 2'd0;
        end
        else
        begin
            if (cmd.set_err)
                err_reg <= 1'b1;
            if (cmd.clr_count)
                count_reg <= '0;
            if (cmd.absorb)
            begin
                if (!mode_reg)
                begin
                    if (!is_dot)
                    begin
                        if (lbl_full)
                            err_reg <= 1'b1;
                        else
                            count_reg <= count_reg + CW'(1);
                    end
                end
                else if (is_dot)
                begin
                    if ((cur_len == 2'd0) || (idx_reg == 2'd3))
                        err_reg <= 1'b1;
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                else if (is_digit)
                begin
                    if (cur_len == 2'd3)
                        err_reg <= 1'b1;
                    else
                        len_reg[idx_reg] <= cur_len + 2'd1;
                end
                else
                begin
                    err_reg <= 1'b1;
                end
            end
        end
    end

    // read pointer and group counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            grp_reg <= 2'd0;
        end
        else
        begin
            if (cmd.ptr_clr)
                ptr_reg <= '0;
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + PW'(1);
            if (cmd.grp_load)
                grp_reg <= idx_reg;
            else if (cmd.grp_dec)
                grp_reg <= grp_reg - 2'd1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output byte source, stores read straight into the output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.sel)
                dqle_pkg::SEL_LLEN:  byte_reg <= 8'(count_reg);
                dqle_pkg::SEL_LBYTE: byte_reg <= label_mem[ptr_reg[IW-1:0]];
                dqle_pkg::SEL_GLEN:  byte_reg <= {6'b000000, len_reg[grp_reg]};
                dqle_pkg::SEL_GBYTE: byte_reg <= oct_mem[oct_rd_addr];
                dqle_pkg::SEL_SFX:   byte_reg <= dqle_pkg::sfx_byte(ptr_reg[3:0]);
                default:             byte_reg <= 8'h00;
            endcase
            final_reg <= (cmd.sel == dqle_pkg::SEL_FINAL);
            bad_reg   <= (cmd.sel == dqle_pkg::SEL_FINAL) && err_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign wire_byte  = byte_reg;
    assign final_byte = final_reg;
    assign bad_name   = bad_reg;

endmodule

[hw/rtl/dqle_ctrl.sv]
module dqle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dqle_pkg::dqle_stat_t stat,
    output dqle_pkg::dqle_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_STEP   = 4'd1;
    localparam logic [3:0] S_REL    = 4'd2;
    localparam logic [3:0] S_LBYTE  = 4'd3;
    localparam logic [3:0] S_CHECK  = 4'd4;
    localparam logic [3:0] S_GLEN   = 4'd5;
    localparam logic [3:0] S_GBYTE  = 4'd6;
    localparam logic [3:0] S_SFX    = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] after_label;

    // after a released label: terminator on last character, else next request
    assign after_label = stat.eos ? S_FINISH : S_IDLE;
    assign in_ready    = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.absorb = 1'b1;
                if (stat.mode)
                    state_next = stat.eos ? S_CHECK : S_IDLE;
                else if (stat.is_dot || stat.eos)
                    state_next = S_REL;
                else
                    state_next = S_IDLE;
            end
            S_REL:
            begin
                if (stat.count_zero)
                begin
                    cmd.set_err   = 1'b1;
                    cmd.clr_count = 1'b1;
                    state_next    = after_label;
                end
                else if (stat.err)
                begin
                    cmd.clr_count = 1'b1;
                    state_next    = after_label;
                end
                else if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = dqle_pkg::SEL_LLEN;
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_LBYTE;
                end
            end
            S_LBYTE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = dqle_pkg::SEL_LBYTE;
                    cmd.ptr_inc = 1'b1;
                    if (stat.label_last)
                    begin
                        cmd.clr_count = 1'b1;
                        state_next    = after_label;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.err || stat.tail_err)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.grp_load = 1'b1;
                    state_next   = S_GLEN;
                end
            end
            S_GLEN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = dqle_pkg::SEL_GLEN;
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_GBYTE;
                end
            end
            S_GBYTE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = dqle_pkg::SEL_GBYTE;
                    cmd.ptr_inc = 1'b1;
                    if (stat.group_last)
                    begin
                        if (stat.grp_zero)
                        begin
                            cmd.ptr_clr = 1'b1;
                            state_next  = S_SFX;
                        end
                        else
                        begin
                            cmd.grp_dec = 1'b1;
                            state_next  = S_GLEN;
                        end
                    end
                end
            end
            S_SFX:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sel     = dqle_pkg::SEL_SFX;
                    cmd.ptr_inc = 1'b1;
                    if (stat.sfx_last)
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.sel        = dqle_pkg::SEL_FINAL;
                    cmd.clear_name = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/dns_qname_label_encoder_core.sv]
// sequence: a request is taken in the idle state and worked in the step state after it; in A mode the
//   first result is registered from the release state, in PTR mode only after a further check state
// flow: no new character is taken until the last one is worked and the bytes that it releases are
//   emitted, and a stalled result holds the controller
// reset: rst_n clears mode (A), counts, group index, error and output valid; stores keep data
module dns_qname_label_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] name_char,
    input  logic       end_of_name,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] wire_byte,
    output logic       final_byte,
    output logic       bad_name
);

    dqle_pkg::dqle_cmd_t  cmd;
    dqle_pkg::dqle_stat_t stat;

    // sequencer
    dqle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // stores, counters and output register
    dqle_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .name_char   (name_char),
        .end_of_name (end_of_name),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .wire_byte   (wire_byte),
        .final_byte  (final_byte),
        .bad_name    (bad_name)
    );

endmodule

[hw/rtl/dqle_checker.sv]
module dqle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] wire_byte,
    input logic       final_byte,
    input logic       bad_name
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wire_byte) &&
        $stable(final_byte) && $stable(bad_name))
        else $error("result changed while stalled");

    // error flag only on the closing result
    a_bad_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_name |-> final_byte)
        else $error("error flag without final");

    // closing result carries a zero byte
    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_byte |-> wire_byte == 8'h00)
        else $error("final result byte not zero");

    // one character at a time: no request right after an accepted one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken in back-to-back cycles");

endmodule

bind dns_qname_label_encoder_core dqle_checker u_dqle_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .wire_byte  (wire_byte),
    .final_byte (final_byte),
    .bad_name   (bad_name)
);

[tb/dns_qname_label_encoder_core_test.sv]
`timescale 1ns / 100ps

module dns_qname_label_encoder_core_test;

    // query modes
    localparam logic MODE_A   = 1'b0;
    localparam logic MODE_PTR = 1'b1;

    localparam int    CLK_HALF      = 10;
    localparam int    RESET_CYCLES  = 5;
    localparam int    RANDOM_ITEMS  = 430;
    localparam int    IDLE_CYCLES   = 8;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    DRAIN_CYCLES  = 40;
    localparam longint RUN_LIMIT_NS = 20_000_000;

    // one byte of the encoded question name
    typedef struct packed {
        logic [7:0] wb;
        logic       fin;
        logic       bad;
    } qname_byte_t;

    // one character request, with an optional typed last byte
    typedef struct packed {
        logic [7:0]  ch;
        logic        eos;
        logic        typed;
        qname_byte_t tres;
    } name_item_t;

    // directed row: a mode write or a character
    typedef struct packed {
        logic       cfg;
        logic       mode;
        name_item_t item;
    } stim_row_t;

    typedef enum int {PAT_OPEN, PAT_COIN, PAT_COMB, PAT_SPARSE} recv_pat_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_we      = 1'b0;
    logic       cfg_data    = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] name_char   = 8'h00;
    logic       end_of_name = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] wire_byte;
    logic       final_byte;
    logic       bad_name;

    dns_qname_label_encoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .name_char   (name_char),
        .end_of_name (end_of_name),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .wire_byte   (wire_byte),
        .final_byte  (final_byte),
        .bad_name    (bad_name)
    );

    always #(CLK_HALF) clk = ~clk;

    // directed requests
    localparam int N_ROWS = 29;
    stim_row_t stim_tab [0:N_ROWS-1] = '{
        // single label right after reset
        '{1'b0, MODE_A, '{"a",     1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}}},
        // extreme character values
        '{1'b0, MODE_A, '{8'h00,   1'b0, 1'b0, '0}},
        '{1'b0, MODE_A, '{8'hFF,   1'b0, 1'b0, '0}},
        '{1'b0, MODE_A, '{".",     1'b0, 1'b0, '0}},
        '{1'b0, MODE_A, '{8'h7F,   1'b1, 1'b0, '0}},
        // lone final dot is an empty label
        '{1'b0, MODE_A, '{".",     1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}},
        // final dot closing a label
        '{1'b0, MODE_A, '{"x",     1'b0, 1'b0, '0}},
        '{1'b0, MODE_A, '{".",     1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}}},
        // leading dot
        '{1'b0, MODE_A, '{".",     1'b0, 1'b0, '0}},
        '{1'b0, MODE_A, '{"b",     1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}},
        '{1'b1, MODE_PTR, '0},
        // four group address
        '{1'b0, MODE_PTR, '{"1",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{".",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{"2",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{".",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{"3",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{".",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{"4",   1'b1, 1'b0, '0}},
        // one group only
        '{1'b0, MODE_PTR, '{"9",   1'b1, 1'b0, '0}},
        // character just past the digits
        '{1'b0, MODE_PTR, '{":",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}},
        // final dot
        '{1'b0, MODE_PTR, '{"1",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{".",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}},
        // fourth digit in a group
        '{1'b0, MODE_PTR, '{"1",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{"2",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{"3",   1'b0, 1'b0, '0}},
        '{1'b0, MODE_PTR, '{"4",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}},
        // name left open, then dropped by the mode write
        '{1'b0, MODE_PTR, '{"5",   1'b0, 1'b0, '0}},
        '{1'b1, MODE_A, '0},
        '{1'b0, MODE_A, '{"z",     1'b1, 1'b0, '0}}
    };

    // predictor state
    logic       pm_mode = MODE_A;
    logic [7:0] lbl_store [dqle_pkg::LABEL_MAX];
    int         lbl_cnt = 0;
    logic [7:0] oct_store [dqle_pkg::OCT_DEPTH];
    int         oct_len [dqle_pkg::GROUPS] = '{default: 0};
    int         oct_idx = 0;
    logic       pm_err  = 1'b0;

    qname_byte_t wire_q [$];
    name_item_t  send_q [$];
    name_item_t  cur_item = '0;

    bit        in_fire      = 1'b0;
    int        items_queued = 0;
    int        items_taken  = 0;
    int        random_items = 0;
    int        fails        = 0;
    int        bytes_seen   = 0;
    int        burst_left   = 1;
    int        gap_left     = 0;
    bit        hold_req     = 1'b0;
    int        hold_left    = 0;
    recv_pat_t pat_kind     = PAT_OPEN;
    int        pat_left     = 0;
    int        pat_tick     = 0;

    function automatic void push_wire(logic [7:0] b, logic f, logic bad);
        qname_byte_t r;
        r.wb  = b;
        r.fin = f;
        r.bad = bad;
        wire_q.push_back(r);
    endfunction

    function automatic void push_text_label(string s);
        int i;
        push_wire(8'(s.len()), 1'b0, 1'b0);
        for (i = 0; i < s.len(); i++)
            push_wire(s[i], 1'b0, 1'b0);
    endfunction

    function automatic void clear_name_state();
        int g;
        lbl_cnt = 0;
        for (g = 0; g < dqle_pkg::GROUPS; g++)
            oct_len[g] = 0;
        oct_idx = 0;
        pm_err  = 1'b0;
    endfunction

    // length byte then label bytes, unless the name is already bad
    function automatic void release_label_bytes();
        int i;
        if (lbl_cnt == 0)
            pm_err = 1'b1;
        else if (!pm_err)
        begin
            push_wire(8'(lbl_cnt), 1'b0, 1'b0);
            for (i = 0; i < lbl_cnt; i++)
                push_wire(lbl_store[i], 1'b0, 1'b0);
        end
        lbl_cnt = 0;
    endfunction

    function automatic void close_name();
        push_wire(8'h00, 1'b1, pm_err);
        clear_name_state();
    endfunction

    // expected wire bytes caused by one character
    function automatic void encode_char(logic [7:0] c, logic e);
        int idx;
        int total;
        int g;
        int i;
        if (pm_mode == MODE_A)
        begin
            if (c == dqle_pkg::DOT_CHAR)
                release_label_bytes();
            else if (lbl_cnt >= dqle_pkg::LABEL_MAX)
                pm_err = 1'b1;
            else
            begin
                lbl_store[lbl_cnt] = c;
                lbl_cnt++;
            end
            if (e)
            begin
                if (c != dqle_pkg::DOT_CHAR)
                    release_label_bytes();
                close_name();
            end
        end
        else
        begin
            idx = oct_idx;
            if (c == dqle_pkg::DOT_CHAR)
            begin
                if (oct_len[idx] == 0 || idx >= dqle_pkg::GROUPS - 1)
                    pm_err = 1'b1;
                else
                    oct_idx = idx + 1;
            end
            else if (c >= dqle_pkg::ZERO_CHAR && c <= dqle_pkg::NINE_CHAR)
            begin
                if (oct_len[idx] >= dqle_pkg::GROUP_CHARS)
                    pm_err = 1'b1;
                else
                begin
                    oct_store[idx * dqle_pkg::GROUP_CHARS + oct_len[idx]] = c;
                    oct_len[idx]++;
                end
            end
            else
                pm_err = 1'b1;
            if (e)
            begin
                idx = oct_idx;
                if (c == dqle_pkg::DOT_CHAR || oct_len[idx] == 0)
                    pm_err = 1'b1;
                total = idx;
                for (g = 0; g <= idx; g++)
                    total += oct_len[g];
                if (total > dqle_pkg::ADDR_CHARS)
                    pm_err = 1'b1;
                // groups in reverse order, then the fixed suffix
                if (!pm_err)
                begin
                    for (g = idx; g >= 0; g--)
                    begin
                        push_wire(8'(oct_len[g]), 1'b0, 1'b0);
                        for (i = 0; i < oct_len[g]; i++)
                            push_wire(oct_store[g * dqle_pkg::GROUP_CHARS + i], 1'b0, 1'b0);
                    end
                    push_text_label("in-addr");
                    push_text_label("arpa");
                end
                close_name();
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fails++;
    endtask

    // sample requests and results, predict and compare
    always @(posedge clk)
    begin : watch
        qname_byte_t want;
        if (rst_n)
        begin
            in_fire = in_valid && in_ready;
            if (cfg_we)
            begin
                pm_mode = cfg_data;
                clear_name_state();
            end
            if (in_fire)
            begin
                items_taken++;
                encode_char(cur_item.ch, cur_item.eos);
                if (cur_item.typed)
                    wire_q[wire_q.size() - 1] = cur_item.tres;
            end
            if (out_valid && out_ready)
            begin
                if (wire_q.size() == 0)
                    report_mismatch($sformatf("byte %0d unexpected: %h fin %b bad %b",
                        bytes_seen, wire_byte, final_byte, bad_name));
                else
                begin
                    want = wire_q.pop_front();
                    if (wire_byte !== want.wb)
                        report_mismatch($sformatf("byte %0d wire_byte %h, want %h",
                            bytes_seen, wire_byte, want.wb));
                    if (final_byte !== want.fin)
                        report_mismatch($sformatf("byte %0d final_byte %b, want %b",
                            bytes_seen, final_byte, want.fin));
                    if (bad_name !== want.bad)
                        report_mismatch($sformatf("byte %0d bad_name %b, want %b",
                            bytes_seen, bad_name, want.bad));
                end
                bytes_seen++;
            end
        end
    end

    // request side: bursts with random gaps
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (send_q.size() > 0)
            begin
                cur_item = send_q.pop_front();
                in_valid    <= 1'b1;
                name_char   <= cur_item.ch;
                end_of_name <= cur_item.eos;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side: changing stall patterns and one long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_kind = recv_pat_t'($urandom_range(0, 3));
                pat_left = $urandom_range(8, 64);
            end
            pat_left--;
            pat_tick++;
            case (pat_kind)
                PAT_OPEN: out_ready <= 1'b1;
                PAT_COIN: out_ready <= 1'($urandom_range(0, 1));
                PAT_COMB: out_ready <= (pat_tick % 3) != 0;
                default:  out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic queue_item(input name_item_t it);
        send_q.push_back(it);
        items_queued++;
    endtask

    task automatic push_char(input logic [7:0] c, input logic e);
        name_item_t it;
        it       = '0;
        it.ch    = c;
        it.eos   = e;
        queue_item(it);
        random_items++;
    endtask

    function automatic logic [7:0] random_char();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0:       c = dqle_pkg::DOT_CHAR;
            1:       c = 8'(dqle_pkg::ZERO_CHAR + $urandom_range(0, 9));
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // forward names: mostly well formed, some long, overflowing, empty or noise
    task automatic gen_fwd_name();
        int kind, labels, spec, len, j, k;
        logic [7:0] c;
        logic last, fdot;
        kind = $urandom_range(0, 19);
        if (kind >= 17)
        begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
                push_char(random_char(), k == len - 1);
        end
        else
        begin
            labels = $urandom_range(1, 4);
            spec   = $urandom_range(0, labels - 1);
            for (j = 0; j < labels; j++)
            begin
                if (j == spec && kind == 13)
                    len = dqle_pkg::LABEL_MAX;
                else if (j == spec && kind == 14)
                    len = dqle_pkg::LABEL_MAX + $urandom_range(1, 2);
                else if (j == spec && kind == 15)
                    len = 0;
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(9, dqle_pkg::LABEL_MAX - 1);
                else
                    len = $urandom_range(1, 8);
                last = (j == labels - 1);
                fdot = last && (kind == 16 || len == 0);
                for (k = 0; k < len; k++)
                begin
                    c = 8'($urandom_range(0, 254));
                    if (c >= dqle_pkg::DOT_CHAR)
                        c++;
                    push_char(c, last && !fdot && k == len - 1);
                end
                if (!last || fdot)
                    push_char(dqle_pkg::DOT_CHAR, fdot);
            end
        end
    endtask

    // reverse addresses: mostly well formed, some malformed or noise
    task automatic gen_rev_name();
        int kind, groups, spec, len, j, k;
        logic [7:0] c;
        logic last, fdot;
        kind = $urandom_range(0, 19);
        if (kind >= 17)
        begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++)
                push_char(random_char(), k == len - 1);
        end
        else
        begin
            groups = (kind == 14) ? dqle_pkg::GROUPS + 1 :
                     (kind == 11) ? dqle_pkg::GROUPS : $urandom_range(1, 4);
            spec   = $urandom_range(0, groups - 1);
            for (j = 0; j < groups; j++)
            begin
                if (kind == 11)
                    len = dqle_pkg::GROUP_CHARS;
                else if (j == spec && kind == 13)
                    len = dqle_pkg::GROUP_CHARS + 1;
                else if (j == spec && kind == 15)
                    len = 0;
                else
                    len = $urandom_range(1, 3);
                last = (j == groups - 1);
                fdot = last && (kind == 16 || len == 0);
                for (k = 0; k < len; k++)
                begin
                    c = 8'(dqle_pkg::ZERO_CHAR + $urandom_range(0, 9));
                    if (j == spec && kind == 12 && k == 0)
                        c = 8'($urandom_range(0, 255));
                    push_char(c, last && !fdot && k == len - 1);
                end
                if (!last || fdot)
                    push_char(dqle_pkg::DOT_CHAR, fdot);
            end
        end
    endtask

    // all requests taken, all bytes out, and a few quiet cycles
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < IDLE_CYCLES)
        begin
            @(negedge clk);
            if (items_taken == items_queued && wire_q.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin : main
        int row, phase, target, k, len;
        logic m;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (row = 0; row < N_ROWS; row++)
        begin
            if (stim_tab[row].cfg)
                set_mode(stim_tab[row].mode);
            else
                queue_item(stim_tab[row].item);
        end

        // random phases, each under one mode setting
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (phase < 2)
                m = phase[0];
            else
                m = 1'($urandom_range(0, 1));
            set_mode(m);
            if (phase == 0)
                hold_req = 1'b1;
            target = random_items + $urandom_range(40, 80);
            while (random_items < target)
            begin
                if (m == MODE_A)
                    gen_fwd_name();
                else
                    gen_rev_name();
            end
            // leave a name open for the next mode write to drop
            if (random_items < RANDOM_ITEMS && $urandom_range(0, 2) == 0)
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    push_char(random_char(), 1'b0);
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (wire_q.size() != 0)
            report_mismatch($sformatf("%0d bytes never arrived", wire_q.size()));
        if (fails == 0)
            $display("dns_qname_label_encoder_core test passed");
        else
            $display("dns_qname_label_encoder_core test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("dns_qname_label_encoder_core test failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dqle_pkg.sv
hw/rtl/dqle_datapath.sv
hw/rtl/dqle_ctrl.sv
hw/rtl/dns_qname_label_encoder_core.sv
hw/rtl/dqle_checker.sv
tb/dns_qname_label_encoder_core_test.sv
